// ----- src/yuv422_pkg.sv -----
// ----------------------------------------------------------------------------
// yuv422_pkg: shared types and constants for the packed 4:2:2 to RGB block
// Holds the layout codes, the Q16 color coefficients and the datapath types.
// ----------------------------------------------------------------------------
package yuv422_pkg;

    // Byte order codes of the layout register.
    localparam logic [1:0] LAYOUT_YUYV  = 2'd0;
    localparam logic [1:0] LAYOUT_UYVY  = 2'd1;
    localparam logic [1:0] LAYOUT_YVYU  = 2'd2;
    localparam logic [1:0] LAYOUT_UNSUP = 2'd3;

    // Layout register value after reset.
    localparam logic [1:0] LAYOUT_RESET = LAYOUT_YUYV;

    // Chroma offset and channel limit.
    localparam logic [7:0] CHROMA_OFFSET = 8'd128;
    localparam logic [7:0] CHAN_MAX      = 8'd255;

    // Q16 products and sums fit in 27 signed bits.
    typedef logic signed [26:0] t_q16;
    typedef logic signed [8:0]  t_chroma;
    typedef logic [7:0]         t_byte;
    typedef logic [31:0]        t_word;

    // Unsigned Q16 coefficients (real value times 65536, rounded).
    localparam t_q16 CB_U = 27'sd132933;
    localparam t_q16 CG_U = 27'sd25817;
    localparam t_q16 CG_V = 27'sd38064;
    localparam t_q16 CR_V = 27'sd74727;

endpackage

// ----- src/yuv422_if.sv -----
// ----------------------------------------------------------------------------
// yuv422 interfaces: handshake channels of the packed 4:2:2 to RGB block
// Packed word input channel, RGB pair output channel and layout write channel.
// ----------------------------------------------------------------------------

// Input channel: one packed 4:2:2 word per item.
interface yuv422_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] packed_word;

    modport source (output valid, output packed_word, input ready);
    modport sink   (input valid, input packed_word, output ready);
endinterface

// Output channel: two RGB pixels and the layout error flag per item.
interface yuv422_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue_first;
    logic [7:0] green_first;
    logic [7:0] red_first;
    logic [7:0] blue_second;
    logic [7:0] green_second;
    logic [7:0] red_second;
    logic       layout_error;

    modport source (
        output valid, output blue_first, output green_first, output red_first,
        output blue_second, output green_second, output red_second,
        output layout_error, input ready
    );
    modport sink (
        input valid, input blue_first, input green_first, input red_first,
        input blue_second, input green_second, input red_second,
        input layout_error, output ready
    );
endinterface

// Configuration channel: write data of the layout register.
interface yuv422_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/packed_yuv422_to_rgb.sv -----
// ----------------------------------------------------------------------------
// packed_yuv422_to_rgb: packed 4:2:2 word to two RGB pixels
// Four-stage pipeline: unpack, chroma multiply, channel sum, clamp.
// ----------------------------------------------------------------------------
// The block takes one 32-bit packed 4:2:2 word per item and returns one item
// with the blue, green and red of both pixels, each clamped to 0..255. It
// accepts one item every clock cycle unless every stage holds an item and the
// output stalls. Each item passes through the four register stages (unpack,
// constant multiply, channel sum, clamp), the last of which is the output
// register. A stalled output holds the pipeline without losing items, and
// empty stages still fill while the output waits. The layout register
// selects YUYV (0), UYVY (1) or YVYU (2); code 3 flags layout_error and
// gives all-zero pixels. Write the layout only while no item is in flight.
module packed_yuv422_to_rgb (
    input  logic                i_clk,
    input  logic                i_rst_n,
    yuv422_cfg_if.sink          i_cfg,
    yuv422_in_if.sink           i_pix,
    yuv422_out_if.source        o_rgb
);
    import yuv422_pkg::*;

    // Layout register.
    logic [1:0] r_layout;

    // Stage valid bits and advance enables.
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    // Stage 1: unpacked samples and offset chroma.
    t_byte   r_y0_s1, r_y1_s1;
    t_chroma r_u_s1, r_v_s1;
    logic    r_err_s1;
    t_byte   n_y0, n_y1, n_ub, n_vb;

    // Stage 2: chroma products and luma bases.
    t_q16 r_base0_s2, r_base1_s2;
    t_q16 r_pb_s2, r_pgu_s2, r_pgv_s2, r_pr_s2;
    logic r_err_s2;

    // Stage 3: channel sums for both pixels.
    t_q16 r_b0_s3, r_g0_s3, r_r0_s3, r_b1_s3, r_g1_s3, r_r1_s3;
    logic r_err_s3;

    // Stage 4: output register.
    t_byte r_b0, r_g0, r_r0, r_b1, r_g1, r_r1;
    logic  r_err;

    // Truncate a Q16 sum to its integer part and clamp it to 0..255.
    function automatic t_byte clamp_q16(input t_q16 sum);
        t_byte res;
        if (sum[26]) begin
            res = 8'd0;
        end else if (sum[25:24] != 2'b00) begin
            res = CHAN_MAX;
        end else begin
            res = sum[23:16];
        end
        return res;
    endfunction

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout <= LAYOUT_RESET;
        end else if (i_cfg.valid) begin
            r_layout <= i_cfg.data;
        end
    end

    // A stage advances when it is empty or the stage after it advances.
    assign en4 = !r_v4 || o_rgb.ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_pix.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_pix.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // Byte selection by layout.
    always_comb begin
        case (r_layout)
            LAYOUT_UYVY: begin
                n_ub = i_pix.packed_word[7:0];
                n_y0 = i_pix.packed_word[15:8];
                n_vb = i_pix.packed_word[23:16];
                n_y1 = i_pix.packed_word[31:24];
            end
            LAYOUT_YVYU: begin
                n_y0 = i_pix.packed_word[7:0];
                n_vb = i_pix.packed_word[15:8];
                n_y1 = i_pix.packed_word[23:16];
                n_ub = i_pix.packed_word[31:24];
            end
            default: begin
                n_y0 = i_pix.packed_word[7:0];
                n_ub = i_pix.packed_word[15:8];
                n_y1 = i_pix.packed_word[23:16];
                n_vb = i_pix.packed_word[31:24];
            end
        endcase
    end

    // Stage 1: unpack and remove the chroma offset.
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_y0_s1  <= n_y0;
            r_y1_s1  <= n_y1;
            r_u_s1   <= $signed({1'b0, n_ub}) - $signed({1'b0, CHROMA_OFFSET});
            r_v_s1   <= $signed({1'b0, n_vb}) - $signed({1'b0, CHROMA_OFFSET});
            r_err_s1 <= (r_layout == LAYOUT_UNSUP);
        end
    end

    // Stage 2: constant multiplies, shared by both pixels.
    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_base0_s2 <= t_q16'({r_y0_s1, 16'h0000});
            r_base1_s2 <= t_q16'({r_y1_s1, 16'h0000});
            r_pb_s2    <= CB_U * t_q16'(r_u_s1);
            r_pgu_s2   <= CG_U * t_q16'(r_u_s1);
            r_pgv_s2   <= CG_V * t_q16'(r_v_s1);
            r_pr_s2    <= CR_V * t_q16'(r_v_s1);
            r_err_s2   <= r_err_s1;
        end
    end

    // Stage 3: channel sums in signed Q16.
    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_b0_s3  <= r_base0_s2 + r_pb_s2;
            r_g0_s3  <= r_base0_s2 - r_pgu_s2 - r_pgv_s2;
            r_r0_s3  <= r_base0_s2 + r_pr_s2;
            r_b1_s3  <= r_base1_s2 + r_pb_s2;
            r_g1_s3  <= r_base1_s2 - r_pgu_s2 - r_pgv_s2;
            r_r1_s3  <= r_base1_s2 + r_pr_s2;
            r_err_s3 <= r_err_s2;
        end
    end

    // Stage 4: clamp, and zero the pixels for an unsupported layout.
    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_b0  <= r_err_s3 ? 8'd0 : clamp_q16(r_b0_s3);
            r_g0  <= r_err_s3 ? 8'd0 : clamp_q16(r_g0_s3);
            r_r0  <= r_err_s3 ? 8'd0 : clamp_q16(r_r0_s3);
            r_b1  <= r_err_s3 ? 8'd0 : clamp_q16(r_b1_s3);
            r_g1  <= r_err_s3 ? 8'd0 : clamp_q16(r_g1_s3);
            r_r1  <= r_err_s3 ? 8'd0 : clamp_q16(r_r1_s3);
            r_err <= r_err_s3;
        end
    end

    assign o_rgb.valid        = r_v4;
    assign o_rgb.blue_first   = r_b0;
    assign o_rgb.green_first  = r_g0;
    assign o_rgb.red_first    = r_r0;
    assign o_rgb.blue_second  = r_b1;
    assign o_rgb.green_second = r_g1;
    assign o_rgb.red_second   = r_r1;
    assign o_rgb.layout_error = r_err;

`ifndef SYNTH
    // An item flagged with a layout error carries all-zero pixels.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r_err) |-> ((r_b0 | r_g0 | r_r0 | r_b1 | r_g1 | r_r1) == 8'd0))
        else $error("layout error item with nonzero pixels");

    // The input is refused only when every stage holds an item and the output stalls.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (r_v1 && r_v2 && r_v3 && r_v4 && !o_rgb.ready))
        else $error("input refused with room in the pipeline");

    // Without an output handshake no item leaves the pipeline.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(o_rgb.valid && o_rgb.ready))
        |-> ($countones({r_v1, r_v2, r_v3, r_v4})
             >= $countones($past({r_v1, r_v2, r_v3, r_v4}))))
        else $error("item lost inside the pipeline");

    // A stalled output stage holds its item and the stage before it holds too.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(r_v4 && r_v3 && !o_rgb.ready)) |-> (r_v4 && r_v3))
        else $error("stalled stage dropped its item");
`endif

endmodule

// ----- bench/tb_packed_yuv422_to_rgb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packed_yuv422_to_rgb: self-checking bench for the 4:2:2 to RGB converter
// Feeds packed words under every byte layout and checks each pixel pair
// against a bit-exact Q16 predictor, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_packed_yuv422_to_rgb;
    import yuv422_pkg::*;

    // Q16 color coefficients and chroma midpoint.
    localparam longint Q_BLUE_U  = 132933;
    localparam longint Q_GREEN_U = 25817;
    localparam longint Q_GREEN_V = 38064;
    localparam longint Q_RED_V   = 74727;
    localparam longint CHROMA_MID = 128;

    // Idle cycles without any item moving before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_WORDS = 1200;

    // One pixel pair as it leaves the block.
    typedef struct packed {
        logic [7:0] blue_first;
        logic [7:0] green_first;
        logic [7:0] red_first;
        logic [7:0] blue_second;
        logic [7:0] green_second;
        logic [7:0] red_second;
        logic       layout_error;
    } t_rgb_pair;

    // One entry of the feed: either a packed word or a layout write.
    typedef struct {
        bit          is_layout;
        logic [31:0] word;
        logic [1:0]  layout;
    } t_feed_entry;

    logic clk = 1'b0;
    logic rst_n;

    yuv422_cfg_if layout_ch ();
    yuv422_in_if  pix_ch ();
    yuv422_out_if rgb_ch ();

    packed_yuv422_to_rgb uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (layout_ch),
        .i_pix   (pix_ch),
        .o_rgb   (rgb_ch)
    );

    t_feed_entry feed_q[$];
    t_rgb_pair   rgb_expected[$];
    logic [1:0]  active_layout = LAYOUT_YUYV;
    int          entries_total = 0;
    int          entries_done = 0;
    int          words_in = 0;
    int          pairs_out = 0;
    int          mismatches = 0;
    bit          pix_taken = 1'b0;
    bit          layout_taken = 1'b0;
    int          src_gap = 0;
    int          src_calm = 0;
    int          snk_stall = 0;
    int          snk_calm = 0;
    int          squeeze_left = 0;
    int          next_squeeze = 300;
    int          idle_cycles = 0;

    always #2 clk = ~clk;

    // Drop the fraction bits of a signed Q16 sum and clamp it to a byte.
    function automatic logic [7:0] sat_q16(input longint sum);
        if (sum < 0) return 8'd0;
        if ((sum >>> 16) > 255) return 8'hFF;
        return sum[23:16];
    endfunction

    // Expected pixel pair for one packed word under the given layout.
    function automatic t_rgb_pair yuv_to_rgb_pair(input logic [1:0] layout,
                                                  input logic [31:0] word);
        t_rgb_pair px;
        longint    y0, y1, u, v;
        px = '0;
        y0 = 0; y1 = 0; u = 0; v = 0;
        case (layout)
            LAYOUT_YUYV: begin
                y0 = longint'(word[7:0]);   u = longint'(word[15:8]);
                y1 = longint'(word[23:16]); v = longint'(word[31:24]);
            end
            LAYOUT_UYVY: begin
                u = longint'(word[7:0]);    y0 = longint'(word[15:8]);
                v = longint'(word[23:16]);  y1 = longint'(word[31:24]);
            end
            LAYOUT_YVYU: begin
                y0 = longint'(word[7:0]);   v = longint'(word[15:8]);
                y1 = longint'(word[23:16]); u = longint'(word[31:24]);
            end
            default: px.layout_error = 1'b1;
        endcase
        if (!px.layout_error) begin
            u = u - CHROMA_MID;
            v = v - CHROMA_MID;
            px.blue_first   = sat_q16(y0 * 65536 + Q_BLUE_U * u);
            px.green_first  = sat_q16(y0 * 65536 - Q_GREEN_U * u - Q_GREEN_V * v);
            px.red_first    = sat_q16(y0 * 65536 + Q_RED_V * v);
            px.blue_second  = sat_q16(y1 * 65536 + Q_BLUE_U * u);
            px.green_second = sat_q16(y1 * 65536 - Q_GREEN_U * u - Q_GREEN_V * v);
            px.red_second   = sat_q16(y1 * 65536 + Q_RED_V * v);
        end
        return px;
    endfunction

    // Idle length: mostly none, sometimes short, rarely long; calm runs have none.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 59) == 0) calm = $urandom_range(20, 60);
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Print a line for each of the first 100 mismatches and count every mismatch.
    task automatic report_mismatch(input string what);
        if (mismatches < 100) $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_channel(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("pair %0d %s got %0d expected %0d",
                                      pairs_out, name, got, want));
    endtask

    task automatic push_word(input logic [31:0] word);
        t_feed_entry e;
        e.is_layout = 1'b0;
        e.word = word;
        e.layout = '0;
        feed_q.push_back(e);
        entries_total++;
    endtask

    task automatic push_layout(input logic [1:0] layout);
        t_feed_entry e;
        e.is_layout = 1'b1;
        e.word = '0;
        e.layout = layout;
        feed_q.push_back(e);
        entries_total++;
    endtask

    // Sender: offers the feed entries, holding layout writes until the pipe is empty.
    always @(negedge clk) begin : feed_driver
        logic        pix_v;
        logic [31:0] pix_w;
        logic        lay_v;
        logic [1:0]  lay_d;
        pix_v = pix_ch.valid;
        pix_w = pix_ch.packed_word;
        lay_v = layout_ch.valid;
        lay_d = layout_ch.data;
        if (pix_taken) begin
            pix_v = 1'b0;
            pix_taken = 1'b0;
        end
        if (layout_taken) begin
            lay_v = 1'b0;
            layout_taken = 1'b0;
        end
        if (!pix_v) pix_w = $urandom;
        if (!lay_v) lay_d = 2'($urandom);
        if (rst_n && !pix_v && !lay_v && feed_q.size() != 0) begin
            if (src_gap > 0) begin
                src_gap--;
            end else if (feed_q[0].is_layout) begin
                if (rgb_expected.size() == 0) begin
                    lay_v = 1'b1;
                    lay_d = feed_q[0].layout;
                    void'(feed_q.pop_front());
                end
            end else begin
                pix_v = 1'b1;
                pix_w = feed_q[0].word;
                void'(feed_q.pop_front());
                src_gap = pick_gap(src_calm);
            end
        end
        pix_ch.valid <= pix_v;
        pix_ch.packed_word <= pix_w;
        layout_ch.valid <= lay_v;
        layout_ch.data <= lay_d;
    end

    // Receiver: random stalls, plus a long hold-off now and then so the pipe backs up.
    always @(negedge clk) begin : rgb_sink
        if (squeeze_left > 0) begin
            squeeze_left--;
            rgb_ch.ready <= 1'b0;
        end else if (words_in >= next_squeeze) begin
            next_squeeze += 450;
            squeeze_left = 80;
            rgb_ch.ready <= 1'b0;
        end else if (snk_stall > 0) begin
            snk_stall--;
            rgb_ch.ready <= 1'b0;
        end else begin
            rgb_ch.ready <= 1'b1;
            snk_stall = pick_gap(snk_calm);
        end
    end

    // Monitor: tracks layout writes, predicts each accepted word, checks each pair.
    always @(posedge clk) begin : handshake_monitor
        t_rgb_pair want;
        if (rst_n) begin
            if (layout_ch.valid && layout_ch.ready) begin
                active_layout = layout_ch.data;
                layout_taken = 1'b1;
                entries_done++;
            end
            if (pix_ch.valid && pix_ch.ready) begin
                rgb_expected.push_back(yuv_to_rgb_pair(active_layout, pix_ch.packed_word));
                pix_taken = 1'b1;
                entries_done++;
                words_in++;
            end
            if (rgb_ch.valid && rgb_ch.ready) begin
                if (rgb_expected.size() == 0) begin
                    report_mismatch($sformatf("pair %0d arrived with none pending", pairs_out));
                end else begin
                    want = rgb_expected.pop_front();
                    check_channel("blue_first",   rgb_ch.blue_first,   want.blue_first);
                    check_channel("green_first",  rgb_ch.green_first,  want.green_first);
                    check_channel("red_first",    rgb_ch.red_first,    want.red_first);
                    check_channel("blue_second",  rgb_ch.blue_second,  want.blue_second);
                    check_channel("green_second", rgb_ch.green_second, want.green_second);
                    check_channel("red_second",   rgb_ch.red_second,   want.red_second);
                    check_channel("layout_error", {7'd0, rgb_ch.layout_error},
                                  {7'd0, want.layout_error});
                end
                pairs_out++;
            end
        end
    end

    // Watchdog: ends the run when no item moves on any channel for too long.
    always @(posedge clk) begin : watchdog
        if ((layout_ch.valid && layout_ch.ready) || (pix_ch.valid && pix_ch.ready) ||
            (rgb_ch.valid && rgb_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus: directed corner words per layout, then random phases.
    initial begin : stimulus
        logic [31:0] w;
        logic [1:0]  lay;
        int          phase;
        int          n;
        int          random_words;
        rst_n = 1'b0;
        pix_ch.valid = 1'b0;
        pix_ch.packed_word = '0;
        layout_ch.valid = 1'b0;
        layout_ch.data = '0;
        rgb_ch.ready = 1'b0;

        // Default layout after reset: black, white, gray, saturating chroma.
        push_word(32'h0000_0000); push_word(32'hFFFF_FFFF); push_word(32'h8080_8080);
        push_word(32'h80FF_80FF); push_word(32'h8000_8000); push_word(32'hFF00_FF00);
        push_word(32'h00FF_00FF); push_word(32'h00FF_FF00); push_word(32'hAAAA_AAAA);
        push_word(32'h5555_5555); push_word(32'h01FE_7F81); push_word(32'hFF10_EB80);
        // Chroma-first layout.
        push_layout(LAYOUT_UYVY);
        push_word(32'h0000_0000); push_word(32'hFFFF_FFFF);
        push_word(32'h80FF_80FF); push_word(32'h1234_5678);
        // Swapped chroma layout.
        push_layout(LAYOUT_YVYU);
        push_word(32'h0000_0000); push_word(32'hFFFF_FFFF);
        push_word(32'hFF00_FF00); push_word(32'h1234_5678);
        // Unsupported layout: error flag and zero pixels.
        push_layout(LAYOUT_UNSUP);
        push_word(32'h0000_0000); push_word(32'hFFFF_FFFF); push_word(32'h8080_8080);

        // Random phases; bytes lean toward the clamp corners part of the time.
        random_words = 0;
        phase = 0;
        while (random_words < RANDOM_WORDS) begin
            case (phase)
                0:       lay = LAYOUT_YUYV;
                1:       lay = LAYOUT_UYVY;
                2:       lay = LAYOUT_YVYU;
                3:       lay = LAYOUT_UNSUP;
                default: lay = 2'($urandom_range(0, 3));
            endcase
            push_layout(lay);
            n = (lay == LAYOUT_UNSUP) ? $urandom_range(20, 50) : $urandom_range(100, 200);
            repeat (n) begin
                w = $urandom;
                for (int k = 0; k < 4; k++) begin
                    case ($urandom_range(0, 7))
                        0: w[8*k +: 8] = 8'h00;
                        1: w[8*k +: 8] = 8'hFF;
                        2: w[8*k +: 8] = 8'h80;
                        default: ;
                    endcase
                end
                push_word(w);
                random_words++;
            end
            phase++;
        end

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        wait (entries_done == entries_total && rgb_expected.size() == 0);
        repeat (16) @(posedge clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
